### rtl/sfs_pkg.sv
package sfs_pkg;

	// Default build parameters
	localparam int MAX_FRAMES_DEF = 256;
	localparam int FRAC_BITS_DEF  = 16;

	// Fixed field widths
	localparam int DT_W     = 16;
	localparam int SPEED_W  = 16;
	localparam int PERIOD_W = 24;
	localparam int COUNT_W  = 9;
	localparam int FRAME_W  = 8;
	localparam int TIMER_W  = 32;
	localparam int CFG_W    = 24;
	localparam int CFG_IDX_W = 3;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SPEED  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PAUSE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COUNT  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LOOP   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_EASE   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_ENDS   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_BASE   = 3'd7;

	// Loop modes
	localparam logic [1:0] LOOP_PINGPONG = 2'd0;
	localparam logic [1:0] LOOP_WRAP     = 2'd1;
	localparam logic [1:0] LOOP_ONESHOT  = 2'd2;
	localparam logic [1:0] LOOP_HOLD     = 2'd3;

	// Easing curves; other codes give no fraction
	localparam logic [2:0] EASE_LINEAR = 3'd0;
	localparam logic [2:0] EASE_IN     = 3'd1;
	localparam logic [2:0] EASE_OUT    = 3'd2;
	localparam logic [2:0] EASE_INOUT  = 3'd3;

	// Reset values of the configuration registers
	localparam logic [SPEED_W-1:0]  SPEED_RST  = 16'd256;
	localparam logic [PERIOD_W-1:0] PERIOD_RST = 24'd1000;
	localparam logic [COUNT_W-1:0]  COUNT_RST  = 9'd1;
	localparam logic [1:0]          LOOP_RST   = LOOP_WRAP;
	localparam logic [2:0]          EASE_RST   = EASE_LINEAR;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_ACC,
		ST_CMP,
		ST_DIV,
		ST_SQ,
		ST_EASE,
		ST_OUT
	} sfs_state_t;

	// Divider status
	typedef struct packed {
		logic busy;
		logic done;
	} sfs_div_stat_t;

endpackage

### rtl/sprite_frame_sequencer.sv
// Sprite frame sequencer.
// Input channel (in_valid / in_stall / tick_units): one transfer per animation tick.
// Output channel (out_valid / out_stall / sprite_* / *_now): exactly one result per tick.
// Configuration: cfg_we writes cfg_data into register cfg_index; write only while idle.
// One tick at a time: in_stall is high from the accepted transfer until its result
// has been taken. A tick first scales tick_units through the shared multiplier and
// updates the timers; a tick held in a pause then goes straight to the output. Else it
// divides timer by period one quotient bit per cycle unless the period has elapsed,
// squares the fraction on the same multiplier and, once the period has elapsed, steps
// the frame. The states run ST_MUL, ST_ACC, ST_CMP, ST_DIV, ST_SQ, ST_EASE, ST_OUT;
// ST_DIV is skipped when the period has elapsed, and the bit-serial divider makes the
// full path the longest. The next tick can be accepted in the cycle after the result transfer.
// While out_stall is high the result holds and no new tick is taken.
// Reset (arst_n low) clears timers, frame index and flags and loads the register
// defaults: speed 1.0, period 1000, one frame, wrapping, linear easing.
module sprite_frame_sequencer #(
	parameter int MAX_FRAMES = sfs_pkg::MAX_FRAMES_DEF,
	parameter int FRAC_BITS  = sfs_pkg::FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [sfs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sfs_pkg::CFG_W-1:0]      cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [sfs_pkg::DT_W-1:0]       tick_units,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [8:0]                     sprite_whole,
	output logic [15:0]                    sprite_fraction,
	output logic                           sprite_valid,
	output logic [sfs_pkg::FRAME_W-1:0]    frame_now,
	output logic                           paused_now,
	output logic                           reversing_now
);

	localparam int EW = FRAC_BITS + 1;
	localparam int MW = (EW > sfs_pkg::SPEED_W) ? EW : sfs_pkg::SPEED_W;
	localparam int PW = 2 * MW;
	localparam int FW = FRAC_BITS + 16;
	localparam int TW = sfs_pkg::TIMER_W;
	localparam int CW = sfs_pkg::COUNT_W;
	localparam logic [EW-1:0] ONE  = EW'(1) << FRAC_BITS;
	localparam logic [EW-1:0] HALF = EW'(1) << (FRAC_BITS - 1);

	// Configuration registers
	logic [sfs_pkg::SPEED_W-1:0]  speed_q;
	logic [sfs_pkg::PERIOD_W-1:0] period_q;
	logic [sfs_pkg::PERIOD_W-1:0] pause_len_q;
	logic [CW-1:0]                count_q;
	logic [1:0]                   loop_q;
	logic [2:0]                   ease_q;
	logic                         ends_q;
	logic [7:0]                   base_q;

	// Animation state
	logic [TW-1:0]                frame_timer_q;
	logic [TW-1:0]                pause_timer_q;
	logic [sfs_pkg::FRAME_W-1:0]  idx_q;
	logic                         rev_q;
	logic                         pause_q;

	// Working registers
	sfs_pkg::sfs_state_t          state_q, state_nx;
	logic [sfs_pkg::DT_W-1:0]     dt_q;
	logic [PW-1:0]                prod_q;
	logic [EW-1:0]                f_q;
	logic                         elapsed_q;

	// Result registers
	logic [8:0]                   whole_q;
	logic [15:0]                  frac_q;
	logic                         svalid_q;
	logic [sfs_pkg::FRAME_W-1:0]  fnow_q;
	logic                         pnow_q;
	logic                         rnow_q;

	// Sequencer outputs
	logic mul_en;
	logic div_start;

	// Divider link
	logic [FRAC_BITS-1:0]         quo;
	sfs_pkg::sfs_div_stat_t       div_stat;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q     <= sfs_pkg::SPEED_RST;
			period_q    <= sfs_pkg::PERIOD_RST;
			pause_len_q <= '0;
			count_q     <= sfs_pkg::COUNT_RST;
			loop_q      <= sfs_pkg::LOOP_RST;
			ease_q      <= sfs_pkg::EASE_RST;
			ends_q      <= 1'b0;
			base_q      <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sfs_pkg::REG_SPEED:  speed_q     <= cfg_data[sfs_pkg::SPEED_W-1:0];
				sfs_pkg::REG_PERIOD: period_q    <= cfg_data;
				sfs_pkg::REG_PAUSE:  pause_len_q <= cfg_data;
				sfs_pkg::REG_COUNT:  count_q     <= cfg_data[CW-1:0];
				sfs_pkg::REG_LOOP:   loop_q      <= cfg_data[1:0];
				sfs_pkg::REG_EASE:   ease_q      <= cfg_data[2:0];
				sfs_pkg::REG_ENDS:   ends_q      <= cfg_data[0];
				sfs_pkg::REG_BASE:   base_q      <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Effective period and frame count
	logic [sfs_pkg::PERIOD_W-1:0] period_eff;
	logic [CW-1:0]                n_eff;
	always_comb begin
		period_eff = (period_q == '0) ? sfs_pkg::PERIOD_W'(1) : period_q;
		if (count_q == '0)
			n_eff = CW'(1);
		else if (count_q > CW'(MAX_FRAMES))
			n_eff = CW'(MAX_FRAMES);
		else
			n_eff = count_q;
	end

	// Timer accumulation with saturation
	logic [sfs_pkg::PERIOD_W-1:0] adj;
	logic [TW:0]                  ft_sum;
	logic [TW:0]                  pt_sum;
	logic [TW-1:0]                ft_sat;
	logic [TW-1:0]                pt_sat;
	logic                         hold;
	logic                         elapsed;
	always_comb begin
		adj     = prod_q[8 +: sfs_pkg::PERIOD_W];
		ft_sum  = {1'b0, frame_timer_q} + (TW + 1)'(adj);
		pt_sum  = {1'b0, pause_timer_q} + (TW + 1)'(adj);
		ft_sat  = ft_sum[TW] ? '1 : ft_sum[TW-1:0];
		pt_sat  = pt_sum[TW] ? '1 : pt_sum[TW-1:0];
		hold    = pause_q && (pt_sat < TW'(pause_len_q));
		elapsed = (frame_timer_q >= TW'(period_eff));
	end

	// Shared multiplier operands: scaling, then squaring
	logic [EW-1:0] sq_in;
	logic          low_half;
	logic [MW-1:0] mul_a;
	logic [MW-1:0] mul_b;
	always_comb begin
		low_half = (f_q < HALF);
		case (ease_q)
			sfs_pkg::EASE_OUT:   sq_in = ONE - f_q;
			sfs_pkg::EASE_INOUT: sq_in = low_half ? f_q : ((ONE - f_q) << 1);
			default:             sq_in = f_q;
		endcase
		if (state_q == sfs_pkg::ST_MUL) begin
			mul_a = MW'(dt_q);
			mul_b = MW'(speed_q);
		end else begin
			mul_a = MW'(sq_in);
			mul_b = MW'(sq_in);
		end
	end

	// Easing and position
	logic [EW-1:0] sq;
	logic [EW-1:0] sq2;
	logic [EW-1:0] eased;
	logic [FW-1:0] frac_wide;
	logic [8:0]    whole;
	always_comb begin
		sq  = prod_q[FRAC_BITS +: EW];
		sq2 = prod_q[FRAC_BITS - 1 +: EW];
		case (ease_q)
			sfs_pkg::EASE_LINEAR: eased = f_q;
			sfs_pkg::EASE_IN:     eased = sq;
			sfs_pkg::EASE_OUT:    eased = ONE - sq;
			sfs_pkg::EASE_INOUT:  eased = low_half ? sq2 : (ONE - (sq >> 1));
			default:              eased = '0;
		endcase
		if (eased > ONE)
			eased = ONE;
		frac_wide = {eased[FRAC_BITS-1:0], 16'h0000};
		whole     = {1'b0, base_q} + {1'b0, idx_q} + 9'(eased[FRAC_BITS]);
	end

	// Frame stepping
	logic [CW-1:0]               nxt;
	logic [CW-1:0]               last;
	logic [sfs_pkg::FRAME_W-1:0] idx_nx;
	logic                        rev_nx;
	logic                        pause_nx;
	always_comb begin
		nxt      = {1'b0, idx_q} + CW'(1);
		last     = n_eff - CW'(1);
		idx_nx   = idx_q;
		rev_nx   = rev_q;
		pause_nx = pause_q;
		case (loop_q)
			sfs_pkg::LOOP_PINGPONG: begin
				if (rev_q) begin
					if (idx_q <= sfs_pkg::FRAME_W'(1)) begin
						idx_nx = '0;
						rev_nx = 1'b0;
						if (ends_q)
							pause_nx = 1'b1;
					end else begin
						idx_nx = idx_q - sfs_pkg::FRAME_W'(1);
					end
				end else begin
					if (nxt >= last) begin
						idx_nx = last[sfs_pkg::FRAME_W-1:0];
						rev_nx = 1'b1;
						if (ends_q)
							pause_nx = 1'b1;
					end else begin
						idx_nx = nxt[sfs_pkg::FRAME_W-1:0];
					end
				end
			end
			sfs_pkg::LOOP_WRAP: begin
				if (nxt >= n_eff) begin
					idx_nx = '0;
					if (ends_q)
						pause_nx = 1'b1;
				end else begin
					idx_nx = nxt[sfs_pkg::FRAME_W-1:0];
				end
			end
			sfs_pkg::LOOP_ONESHOT: begin
				if (nxt >= n_eff) begin
					idx_nx   = last[sfs_pkg::FRAME_W-1:0];
					pause_nx = 1'b1;
				end else begin
					idx_nx = nxt[sfs_pkg::FRAME_W-1:0];
				end
			end
			default: ;
		endcase
	end

	// Next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			sfs_pkg::ST_IDLE: if (in_valid) state_nx = sfs_pkg::ST_MUL;
			sfs_pkg::ST_MUL:  state_nx = sfs_pkg::ST_ACC;
			sfs_pkg::ST_ACC:  state_nx = hold ? sfs_pkg::ST_OUT : sfs_pkg::ST_CMP;
			sfs_pkg::ST_CMP:  state_nx = elapsed ? sfs_pkg::ST_SQ : sfs_pkg::ST_DIV;
			sfs_pkg::ST_DIV:  if (div_stat.done) state_nx = sfs_pkg::ST_SQ;
			sfs_pkg::ST_SQ:   state_nx = sfs_pkg::ST_EASE;
			sfs_pkg::ST_EASE: state_nx = sfs_pkg::ST_OUT;
			sfs_pkg::ST_OUT:  if (!out_stall) state_nx = sfs_pkg::ST_IDLE;
			default:          state_nx = sfs_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		in_stall  = 1'b1;
		out_valid = 1'b0;
		mul_en    = 1'b0;
		div_start = 1'b0;
		unique case (state_q)
			sfs_pkg::ST_IDLE: in_stall = 1'b0;
			sfs_pkg::ST_MUL:  mul_en = 1'b1;
			sfs_pkg::ST_CMP:  div_start = !elapsed;
			sfs_pkg::ST_SQ:   mul_en = 1'b1;
			sfs_pkg::ST_OUT:  out_valid = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= sfs_pkg::ST_IDLE;
		else
			state_q <= state_nx;
	end

	// Animation state updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_timer_q <= '0;
			pause_timer_q <= '0;
			idx_q         <= '0;
			rev_q         <= 1'b0;
			pause_q       <= 1'b0;
		end else begin
			if (state_q == sfs_pkg::ST_ACC) begin
				frame_timer_q <= ft_sat;
				if (pause_q) begin
					if (hold) begin
						pause_timer_q <= pt_sat;
					end else begin
						pause_timer_q <= '0;
						pause_q       <= 1'b0;
					end
				end
			end
			if (state_q == sfs_pkg::ST_EASE && elapsed_q) begin
				frame_timer_q <= '0;
				idx_q         <= idx_nx;
				rev_q         <= rev_nx;
				pause_q       <= pause_nx;
			end
		end
	end

	// Working datapath
	always_ff @(posedge clk) begin
		if (state_q == sfs_pkg::ST_IDLE && in_valid)
			dt_q <= tick_units;
		if (mul_en)
			prod_q <= PW'(mul_a) * PW'(mul_b);
		if (state_q == sfs_pkg::ST_CMP) begin
			elapsed_q <= elapsed;
			if (elapsed)
				f_q <= ONE;
		end
		if (state_q == sfs_pkg::ST_DIV && div_stat.done)
			f_q <= {1'b0, quo};
	end

	// Result registers
	always_ff @(posedge clk) begin
		if (state_q == sfs_pkg::ST_ACC && hold) begin
			whole_q  <= '0;
			frac_q   <= '0;
			svalid_q <= 1'b0;
			fnow_q   <= idx_q;
			pnow_q   <= 1'b1;
			rnow_q   <= rev_q;
		end
		if (state_q == sfs_pkg::ST_EASE) begin
			whole_q  <= whole;
			frac_q   <= frac_wide[FRAC_BITS +: 16];
			svalid_q <= 1'b1;
			fnow_q   <= elapsed_q ? idx_nx : idx_q;
			pnow_q   <= elapsed_q ? pause_nx : pause_q;
			rnow_q   <= elapsed_q ? rev_nx : rev_q;
		end
	end

	sfs_div #(
		.FRAC_BITS (FRAC_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (frame_timer_q[sfs_pkg::PERIOD_W-1:0]),
		.divisor  (period_eff),
		.quotient (quo),
		.stat     (div_stat)
	);

	assign sprite_whole    = whole_q;
	assign sprite_fraction = frac_q;
	assign sprite_valid    = svalid_q;
	assign frame_now       = fnow_q;
	assign paused_now      = pnow_q;
	assign reversing_now   = rnow_q;

endmodule

### rtl/sfs_div.sv
// Restoring divider: quotient = (dividend << FRAC_BITS) / divisor, one bit per cycle.
// Requires dividend < divisor, so the quotient fits in FRAC_BITS bits.
module sfs_div #(
	parameter int FRAC_BITS = sfs_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [sfs_pkg::PERIOD_W-1:0]  dividend,
	input  logic [sfs_pkg::PERIOD_W-1:0]  divisor,
	output logic [FRAC_BITS-1:0]          quotient,
	output sfs_pkg::sfs_div_stat_t        stat
);

	localparam int CNT_W = $clog2(FRAC_BITS);
	localparam int RW    = sfs_pkg::PERIOD_W + 1;

	logic [sfs_pkg::PERIOD_W-1:0] rem_q;
	logic [sfs_pkg::PERIOD_W-1:0] dvs_q;
	logic [FRAC_BITS-1:0]         quo_q;
	logic [CNT_W-1:0]             cnt_q;
	logic                         busy_q;
	logic                         done_q;

	logic [RW-1:0] trial;
	logic [RW-1:0] diff;
	logic          fits;

	// One trial subtract per cycle
	always_comb begin
		trial = {rem_q, 1'b0};
		diff  = trial - {1'b0, dvs_q};
		fits  = (trial >= {1'b0, dvs_q});
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(FRAC_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder and quotient
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			dvs_q <= divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? diff[sfs_pkg::PERIOD_W-1:0] : trial[sfs_pkg::PERIOD_W-1:0];
			quo_q <= {quo_q[FRAC_BITS-2:0], fits};
		end
	end

	assign quotient  = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

### rtl/sfs_checker.sv
// Port-level checks on the sequencer
module sfs_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          cfg_we,
	input logic [sfs_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [sfs_pkg::CFG_W-1:0]     cfg_data,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic [sfs_pkg::DT_W-1:0]      tick_units,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [8:0]                    sprite_whole,
	input logic [15:0]                   sprite_fraction,
	input logic                          sprite_valid,
	input logic [sfs_pkg::FRAME_W-1:0]   frame_now,
	input logic                          paused_now,
	input logic                          reversing_now
);

	// An accepted tick keeps the input side closed on the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("tick accepted while previous one in flight");

	// A waiting result blocks new ticks
	a_no_accept_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input open while result pending");

	// Exactly one result per tick: a result transfer is not directly followed by another
	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall |=> !out_valid)
		else $error("result repeated");

	// A held tick reports the pause and an empty position
	a_held_tick: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !sprite_valid |->
			paused_now && sprite_whole == 9'd0 && sprite_fraction == 16'd0)
		else $error("held tick carries a position");

endmodule

bind sprite_frame_sequencer sfs_checker u_sfs_checker (.*);
